// File: design/plst_pkg.sv
// ----------------------------------------------------------------------------
// plst_pkg: shared types and constants of the polyline store
// Opcodes, controller states, datapath step codes, the command and status
// structs that join controller and datapath, and the saturating adder.
// ----------------------------------------------------------------------------
package plst_pkg;

  localparam int unsigned MAX_POINTS_DEF = 1024;
  localparam int unsigned COORD_W        = 16;
  localparam int unsigned OP_W           = 2;
  localparam int unsigned THR_W          = 8;
  localparam logic [THR_W-1:0] THR_RST   = 8'd5;
  localparam int unsigned IN_W           = 8 * COORD_W;

  // Projection divider: quotient never exceeds 16 bits of magnitude plus one
  localparam int unsigned QUO_W = 17;
  localparam int unsigned DEN_W = 33;
  localparam int unsigned NUM_W = DEN_W + QUO_W - 1;
  localparam int unsigned CNT_W = $clog2(QUO_W + 1);

  typedef enum logic [OP_W-1:0] {
    OP_DRAG = 2'd0,
    OP_MOVE = 2'd1,
    OP_HIT  = 2'd2,
    OP_NONE = 2'd3
  } opcode_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DRAG_RD, S_DRAG_DEC, S_DRAG_APP2, S_MOVE_START, S_MOVE_RUN,
    S_HIT_RD0, S_HIT_A, S_HIT_RD, S_HIT_LEN, S_HIT_MUL, S_HIT_SUM, S_HIT_CHK,
    S_HIT_DSTART, S_HIT_DIV, S_HIT_PROJ, S_HIT_DIFF, S_HIT_SQ, S_HIT_CMP,
    S_HIT_NEXT, S_OUT
  } state_e;

  typedef enum logic [4:0] {
    STEP_NONE, STEP_LOAD, STEP_DRAG_RD, STEP_APP_START, STEP_APP_END,
    STEP_CLR_DRAW, STEP_MOVE_START, STEP_MOVE_RUN, STEP_HIT_RD, STEP_HIT_A,
    STEP_HIT_LEN, STEP_HIT_MUL, STEP_HIT_SUM, STEP_HIT_CHK, STEP_HIT_DSTART,
    STEP_HIT_PROJ, STEP_HIT_DIFF, STEP_HIT_SQ, STEP_HIT_CMP, STEP_HIT_NEXT,
    STEP_OUT
  } step_e;

  typedef struct packed {
    step_e step;
  } cmd_t;

  typedef struct packed {
    logic drawing;
    logic end_eq_last;
    logic total_lt2;
    logic move_done;
    logic direct;
    logic div_busy;
    logic hit;
    logic seg_last;
  } status_t;

  // Add an offset and clamp to the 16-bit signed range
  function automatic logic signed [COORD_W-1:0] sat_add(
      input logic signed [COORD_W-1:0] a, input logic signed [COORD_W-1:0] d);
    logic signed [COORD_W:0] s;
    s = {a[COORD_W-1], a} + {d[COORD_W-1], d};
    if (s[COORD_W] != s[COORD_W-1]) begin
      sat_add = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      sat_add = s[COORD_W-1:0];
    end
  endfunction

endpackage

// File: design/plst_div.sv
// ----------------------------------------------------------------------------
// plst_div: restoring divider for the segment projection
// One quotient bit per cycle; the quotient is known to fit QUO_W bits.
// ----------------------------------------------------------------------------
module plst_div import plst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [QUO_W-1:0] quo_o,
  output logic             rem_nz_o
);

  logic [DEN_W-1:0] rem_q;
  logic [QUO_W-1:0] low_q, quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic [DEN_W:0]   trial, diff;

  // Trial subtract of the shifted remainder
  assign trial = {rem_q, low_q[QUO_W-1]};
  assign diff  = trial - {1'b0, den_i};

  // Count the iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(QUO_W);
    end else if (busy_q) begin
      busy_q <= (cnt_q != CNT_W'(1));
      cnt_q  <= cnt_q - CNT_W'(1);
    end
  end

  // Shift remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i[NUM_W-1:QUO_W]};
      low_q <= num_i[QUO_W-1:0];
      quo_q <= '0;
    end else if (busy_q) begin
      low_q <= {low_q[QUO_W-2:0], 1'b0};
      if (!diff[DEN_W]) begin
        rem_q <= diff[DEN_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], 1'b1};
      end else begin
        rem_q <= trial[DEN_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], 1'b0};
      end
    end
  end

  assign busy_o   = busy_q;
  assign quo_o    = quo_q;
  assign rem_nz_o = (rem_q != '0);

endmodule

// File: design/plst_dp.sv
// ----------------------------------------------------------------------------
// plst_dp: point store and arithmetic of the polyline store
// Holds the point memory, count, drawing flag, box and threshold, and runs
// the append, move sweep and segment distance steps that the controller
// commands.
// ----------------------------------------------------------------------------
module plst_dp import plst_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned CW         = $clog2(MAX_POINTS + 1),
  parameter int unsigned AW         = $clog2(MAX_POINTS),
  parameter int unsigned OUT_W      = ((CW + 67 + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  input  logic [IN_W-1:0]  in_data_i,
  input  logic [OP_W-1:0]  in_op_i,
  input  logic             cfg_we_i,
  input  logic [THR_W-1:0] cfg_data_i,
  output logic [OUT_W-1:0] out_data_o
);

  typedef logic signed [COORD_W-1:0] coord_t;

  // Point memory
  coord_t mem_x [MAX_POINTS];
  coord_t mem_y [MAX_POINTS];
  coord_t rd_x_q, rd_y_q;

  // Item fields
  opcode_e op_q;
  coord_t  sx_q, sy_q, ex_q, ey_q, dx_q, dy_q, qx_q, qy_q;

  // Control state
  logic [CW-1:0]    total_q, idx_q;
  logic             drawing_q, hit_q, dropped_q, wv_q;
  coord_t           box_l_q, box_t_q, box_r_q, box_b_q;
  logic [THR_W-1:0] thr_q;
  logic [AW-1:0]    wa_q;

  // Segment arithmetic
  coord_t                ax_q, ay_q;
  logic signed [16:0]    lx_q, ly_q, ux_q, uy_q;
  logic signed [33:0]    pxx_q, pyy_q, pdx_q, pdy_q;
  logic signed [34:0]    len2_q, dot_q;
  logic [NUM_W-1:0]      nx_q, ny_q;
  logic                  nsx_q, nsy_q;
  logic signed [17:0]    cx_q, cy_q;
  logic signed [18:0]    ddx_q, ddy_q;
  logic signed [37:0]    sqx_q, sqy_q;

  // Memory port controls
  logic          we_c, re_c, full_c, app_c;
  logic [AW-1:0] wa_c, ra_c;
  coord_t        wx_c, wy_c, px_c, py_c;

  // Divider hookup and projection
  logic             div_busy, nzx, nzy;
  logic [QUO_W-1:0] qux, quy;
  logic [15:0]      alx, aly;
  logic [NUM_W-1:0] nx_c, ny_c;
  logic signed [18:0] sx_c, sy_c, tqx, tqy, prx_c, pry_c;
  logic             zero_len, neg_dot, past_b;
  logic [8:0]       thr1;
  logic [16:0]      lim;
  logic [38:0]      d2;

  assign full_c = (total_q == CW'(MAX_POINTS));
  assign app_c  = (cmd_i.step == STEP_APP_START) || (cmd_i.step == STEP_APP_END);
  assign px_c   = (cmd_i.step == STEP_APP_START) ? sx_q : ex_q;
  assign py_c   = (cmd_i.step == STEP_APP_START) ? sy_q : ey_q;

  // Select memory write and read
  always_comb begin
    we_c = 1'b0;
    re_c = 1'b0;
    wa_c = total_q[AW-1:0];
    wx_c = px_c;
    wy_c = py_c;
    ra_c = idx_q[AW-1:0];
    unique case (cmd_i.step)
      STEP_APP_START, STEP_APP_END: we_c = !full_c;
      STEP_DRAG_RD: begin
        re_c = 1'b1;
        ra_c = AW'(total_q - CW'(1));
      end
      STEP_MOVE_RUN: begin
        re_c = (idx_q != total_q);
        we_c = wv_q;
        wa_c = wa_q;
        wx_c = sat_add(rd_x_q, dx_q);
        wy_c = sat_add(rd_y_q, dy_q);
      end
      STEP_HIT_RD: re_c = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_c) begin
      mem_x[wa_c] <= wx_c;
      mem_y[wa_c] <= wy_c;
    end
    if (re_c) begin
      rd_x_q <= mem_x[ra_c];
      rd_y_q <= mem_y[ra_c];
    end
  end

  // Classify the segment
  assign zero_len = (len2_q == '0);
  assign neg_dot  = dot_q[34];
  assign past_b   = (dot_q > len2_q);
  assign alx = lx_q[16] ? 16'(-lx_q) : lx_q[15:0];
  assign aly = ly_q[16] ? 16'(-ly_q) : ly_q[15:0];
  assign nx_c = {16'b0, dot_q[32:0]} * {33'b0, alx};
  assign ny_c = {16'b0, dot_q[32:0]} * {33'b0, aly};

  plst_div u_div_x (
    .clk_i, .rst_ni,
    .start_i (cmd_i.step == STEP_HIT_DSTART),
    .num_i   (nx_q), .den_i (len2_q[DEN_W-1:0]),
    .busy_o  (div_busy), .quo_o (qux), .rem_nz_o (nzx)
  );

  plst_div u_div_y (
    .clk_i, .rst_ni,
    .start_i (cmd_i.step == STEP_HIT_DSTART),
    .num_i   (ny_q), .den_i (len2_q[DEN_W-1:0]),
    .busy_o  (), .quo_o (quy), .rem_nz_o (nzy)
  );

  // Floor the projection, then step toward zero when it was inexact
  assign tqx   = 19'({2'b0, qux}) + 19'(nsx_q && nzx);
  assign tqy   = 19'({2'b0, quy}) + 19'(nsy_q && nzy);
  assign sx_c  = 19'(ax_q) + (nsx_q ? -tqx : tqx);
  assign sy_c  = 19'(ay_q) + (nsy_q ? -tqy : tqy);
  assign prx_c = sx_c + 19'(sx_c[18] && nzx);
  assign pry_c = sy_c + 19'(sy_c[18] && nzy);

  assign thr1 = {1'b0, thr_q} + 9'd1;
  assign lim  = {8'b0, thr1} * {8'b0, thr1};
  assign d2   = {1'b0, sqx_q} + {1'b0, sqy_q};

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      idx_q     <= '0;
      drawing_q <= 1'b0;
      hit_q     <= 1'b0;
      dropped_q <= 1'b0;
      wv_q      <= 1'b0;
      box_l_q   <= '0;
      box_t_q   <= '0;
      box_r_q   <= '0;
      box_b_q   <= '0;
      thr_q     <= THR_RST;
    end else begin
      if (cfg_we_i) thr_q <= cfg_data_i;
      unique case (cmd_i.step)
        STEP_LOAD: begin
          idx_q     <= '0;
          hit_q     <= 1'b0;
          dropped_q <= 1'b0;
        end
        STEP_APP_START, STEP_APP_END: begin
          if (cmd_i.step == STEP_APP_START) drawing_q <= 1'b1;
          if (full_c) begin
            dropped_q <= 1'b1;
          end else begin
            total_q <= total_q + CW'(1);
            if (total_q == '0) begin
              box_l_q <= px_c;
              box_r_q <= px_c;
              box_t_q <= py_c;
              box_b_q <= py_c;
            end else begin
              if (px_c < box_l_q) box_l_q <= px_c;
              if (px_c > box_r_q) box_r_q <= px_c;
              if (py_c < box_t_q) box_t_q <= py_c;
              if (py_c > box_b_q) box_b_q <= py_c;
            end
          end
        end
        STEP_CLR_DRAW: drawing_q <= 1'b0;
        STEP_MOVE_START: begin
          idx_q   <= '0;
          wv_q    <= 1'b0;
          box_l_q <= sat_add(box_l_q, dx_q);
          box_r_q <= sat_add(box_r_q, dx_q);
          box_t_q <= sat_add(box_t_q, dy_q);
          box_b_q <= sat_add(box_b_q, dy_q);
        end
        STEP_MOVE_RUN: begin
          wv_q <= re_c;
          if (re_c) idx_q <= idx_q + CW'(1);
        end
        STEP_HIT_A:    idx_q <= CW'(1);
        STEP_HIT_CMP:  if (d2 < {22'b0, lim}) hit_q <= 1'b1;
        STEP_HIT_NEXT: idx_q <= idx_q + CW'(1);
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.step)
      STEP_LOAD: begin
        op_q <= opcode_e'(in_op_i);
        sx_q <= in_data_i[15:0];
        sy_q <= in_data_i[31:16];
        ex_q <= in_data_i[47:32];
        ey_q <= in_data_i[63:48];
        dx_q <= in_data_i[79:64];
        dy_q <= in_data_i[95:80];
        qx_q <= in_data_i[111:96];
        qy_q <= in_data_i[127:112];
      end
      STEP_MOVE_RUN: wa_q <= idx_q[AW-1:0];
      STEP_HIT_A, STEP_HIT_NEXT: begin
        ax_q <= rd_x_q;
        ay_q <= rd_y_q;
      end
      STEP_HIT_LEN: begin
        lx_q <= 17'(rd_x_q) - 17'(ax_q);
        ly_q <= 17'(rd_y_q) - 17'(ay_q);
        ux_q <= 17'(qx_q) - 17'(ax_q);
        uy_q <= 17'(qy_q) - 17'(ay_q);
      end
      STEP_HIT_MUL: begin
        pxx_q <= lx_q * lx_q;
        pyy_q <= ly_q * ly_q;
        pdx_q <= ux_q * lx_q;
        pdy_q <= uy_q * ly_q;
      end
      STEP_HIT_SUM: begin
        len2_q <= 35'(pxx_q) + 35'(pyy_q);
        dot_q  <= 35'(pdx_q) + 35'(pdy_q);
      end
      STEP_HIT_CHK: begin
        if (zero_len || neg_dot || !past_b) begin
          cx_q <= 18'(ax_q);
          cy_q <= 18'(ay_q);
        end else begin
          cx_q <= 18'(rd_x_q);
          cy_q <= 18'(rd_y_q);
        end
        nx_q  <= nx_c;
        ny_q  <= ny_c;
        nsx_q <= lx_q[16];
        nsy_q <= ly_q[16];
      end
      STEP_HIT_PROJ: begin
        cx_q <= prx_c[17:0];
        cy_q <= pry_c[17:0];
      end
      STEP_HIT_DIFF: begin
        ddx_q <= 19'(qx_q) - 19'(cx_q);
        ddy_q <= 19'(qy_q) - 19'(cy_q);
      end
      STEP_HIT_SQ: begin
        sqx_q <= ddx_q * ddx_q;
        sqy_q <= ddy_q * ddy_q;
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.step == STEP_OUT) begin
      out_data_o <= OUT_W'({dropped_q, box_b_q, box_r_q, box_t_q, box_l_q,
                            total_q, drawing_q, hit_q});
    end
  end

  // Status to the controller
  always_comb begin
    status_o.drawing     = drawing_q;
    status_o.end_eq_last = (total_q == '0) || ((rd_x_q == ex_q) && (rd_y_q == ey_q));
    status_o.total_lt2   = (total_q < CW'(2));
    status_o.move_done   = (idx_q == total_q) && !wv_q;
    status_o.direct      = zero_len || neg_dot || past_b;
    status_o.div_busy    = div_busy;
    status_o.hit         = hit_q;
    status_o.seg_last    = (({1'b0, idx_q} + (CW+1)'(1)) == {1'b0, total_q});
  end

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(MAX_POINTS))
    else $error("point count above store depth");

  a_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_c |-> (app_c || cmd_i.step == STEP_MOVE_RUN))
    else $error("memory write outside append or move");

  a_hit_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> (op_q == OP_HIT))
    else $error("hit flag set for a non hit test item");

  a_append_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (app_c && !full_c) |=> (total_q == $past(total_q) + CW'(1)))
    else $error("append did not advance point count");

endmodule

// File: design/plst_ctrl.sv
// ----------------------------------------------------------------------------
// plst_ctrl: sequencer of the polyline store
// Walks each item through drag, move sweep or per-segment hit test steps,
// and owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module plst_ctrl import plst_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] in_op_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  status_t         status_i,
  output cmd_t            cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (opcode_e'(in_op_i))
            OP_DRAG: state_d = S_DRAG_RD;
            OP_MOVE: state_d = S_MOVE_START;
            OP_HIT:  state_d = S_HIT_RD0;
            OP_NONE: state_d = S_OUT;
          endcase
        end
      end
      S_DRAG_RD:  state_d = S_DRAG_DEC;
      S_DRAG_DEC: state_d = status_i.drawing ? S_OUT : S_DRAG_APP2;
      S_DRAG_APP2:  state_d = S_OUT;
      S_MOVE_START: state_d = S_MOVE_RUN;
      S_MOVE_RUN:   if (status_i.move_done) state_d = S_OUT;
      S_HIT_RD0:    state_d = status_i.total_lt2 ? S_OUT : S_HIT_A;
      S_HIT_A:      state_d = S_HIT_RD;
      S_HIT_RD:     state_d = S_HIT_LEN;
      S_HIT_LEN:    state_d = S_HIT_MUL;
      S_HIT_MUL:    state_d = S_HIT_SUM;
      S_HIT_SUM:    state_d = S_HIT_CHK;
      S_HIT_CHK:    state_d = status_i.direct ? S_HIT_DIFF : S_HIT_DSTART;
      S_HIT_DSTART: state_d = S_HIT_DIV;
      S_HIT_DIV:    if (!status_i.div_busy) state_d = S_HIT_PROJ;
      S_HIT_PROJ:   state_d = S_HIT_DIFF;
      S_HIT_DIFF:   state_d = S_HIT_SQ;
      S_HIT_SQ:     state_d = S_HIT_CMP;
      S_HIT_CMP:    state_d = S_HIT_NEXT;
      S_HIT_NEXT:   state_d = (status_i.hit || status_i.seg_last) ? S_OUT : S_HIT_RD;
      S_OUT:        if (out_free) state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  // Commands and handshake
  always_comb begin
    cmd_o.step  = STEP_NONE;
    in_ready_o  = (state_q == S_IDLE);
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE:       if (in_valid_i) cmd_o.step = STEP_LOAD;
      S_DRAG_RD:    cmd_o.step = STEP_DRAG_RD;
      S_DRAG_DEC: begin
        if (!status_i.drawing)         cmd_o.step = STEP_APP_START;
        else if (!status_i.end_eq_last) cmd_o.step = STEP_APP_END;
        else                           cmd_o.step = STEP_CLR_DRAW;
      end
      S_DRAG_APP2:  cmd_o.step = STEP_APP_END;
      S_MOVE_START: cmd_o.step = STEP_MOVE_START;
      S_MOVE_RUN:   if (!status_i.move_done) cmd_o.step = STEP_MOVE_RUN;
      S_HIT_RD0:    if (!status_i.total_lt2) cmd_o.step = STEP_HIT_RD;
      S_HIT_A:      cmd_o.step = STEP_HIT_A;
      S_HIT_RD:     cmd_o.step = STEP_HIT_RD;
      S_HIT_LEN:    cmd_o.step = STEP_HIT_LEN;
      S_HIT_MUL:    cmd_o.step = STEP_HIT_MUL;
      S_HIT_SUM:    cmd_o.step = STEP_HIT_SUM;
      S_HIT_CHK:    cmd_o.step = STEP_HIT_CHK;
      S_HIT_DSTART: cmd_o.step = STEP_HIT_DSTART;
      S_HIT_PROJ:   cmd_o.step = STEP_HIT_PROJ;
      S_HIT_DIFF:   cmd_o.step = STEP_HIT_DIFF;
      S_HIT_SQ:     cmd_o.step = STEP_HIT_SQ;
      S_HIT_CMP:    cmd_o.step = STEP_HIT_CMP;
      S_HIT_NEXT: begin
        if (!(status_i.hit || status_i.seg_last)) cmd_o.step = STEP_HIT_NEXT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.step  = STEP_OUT;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: design/polyline_store_hit_test_top.sv
// ----------------------------------------------------------------------------
// polyline_store_hit_test_top: polyline store with box and hit test
// Stores polyline points, tracks their bounding box, offsets them and tests
// a query point against every segment.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_axis channel (opcode in tuser, coordinates in
//   tdata); each produces exactly one result on m_axis. cfg_valid_i writes
//   the hit threshold; write it only while the block is idle.
//   The block works on one item at a time; s_axis_tready is high only while
//   it waits for an item. A drag update appends two points when it starts
//   a new stroke. A move sweeps the stored points (one read and one write
//   per cycle). A hit test checks no segment with fewer than two points,
//   else walks the segments; one whose nearest point is not an endpoint
//   needs the projection through the 17-bit serial divider. It stops at
//   the first hit. An unused opcode only produces its result.
//   The result sits in an output register; the next item is accepted as
//   soon as it is loaded, and a stalled receiver holds only the last step.
//   Reset empties the store, clears the box and drawing flag and sets the
//   threshold to 5; no clearing pass runs over the memory.
// ----------------------------------------------------------------------------
module polyline_store_hit_test_top import plst_pkg::*; #(
  parameter int unsigned MAX_POINTS = MAX_POINTS_DEF,
  parameter int unsigned CW         = $clog2(MAX_POINTS + 1),
  parameter int unsigned OUT_W      = ((CW + 67 + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // start_x, start_y, end_x, end_y, delta_x, delta_y, query_x, query_y
  input  logic [IN_W-1:0]  s_axis_tdata,
  // opcode
  input  logic [OP_W-1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // hit, drawing, stored_points, box_left, box_top, box_right, box_bottom,
  // dropped, zero fill
  output logic [OUT_W-1:0] m_axis_tdata,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [THR_W-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  plst_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_op_i     (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  plst_dp #(
    .MAX_POINTS (MAX_POINTS),
    .CW         (CW),
    .AW         ($clog2(MAX_POINTS)),
    .OUT_W      (OUT_W)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (s_axis_tdata),
    .in_op_i    (s_axis_tuser),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (m_axis_tdata)
  );

endmodule
